// ----- rtl/core/dqm_pkg.sv -----
package dqm_pkg;

   // Field widths
   localparam int BYTES_W    = 32;
   localparam int BUDGET_W   = 48;
   localparam int OUT_CNT_W  = 48;
   localparam int PCT_W      = 10;
   localparam int ALERT_W    = 2;

   // Channel widths
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 256;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // Percent arithmetic: x*100 needs 7 extra bits, 11 quotient bits detect saturation
   localparam int PCT_SCALE_W = 7;
   localparam int DIV_STEPS   = PCT_W + 1;
   localparam logic [PCT_W-1:0] PCT_MAX = '1;

   // Request kinds
   localparam logic FUNC_USAGE = 1'b0;
   localparam logic FUNC_RESET = 1'b1;

   // Alert codes
   localparam logic [ALERT_W-1:0] ALERT_NONE = 2'd0;
   localparam logic [ALERT_W-1:0] ALERT_WARN = 2'd1;
   localparam logic [ALERT_W-1:0] ALERT_CRIT = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BUDGET   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WARN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CRIT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AUTO_AGG = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ALERT_EN = 3'd4;

   // Divider control and status
   typedef struct packed {
      logic start;
   } dqm_div_ctl_type;

   typedef struct packed {
      logic             done;
      logic [PCT_W-1:0] pct;
   } dqm_div_sts_type;

endpackage

// ----- rtl/core/dqm_pct_div.sv -----
module dqm_pct_div #(
   parameter int COUNT_WIDTH = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dqm_pkg::dqm_div_ctl_type       ctl,
   input  logic [COUNT_WIDTH-1:0]         dividend,
   input  logic [dqm_pkg::BUDGET_W-1:0]   divisor,
   output dqm_pkg::dqm_div_sts_type       sts
);
   import dqm_pkg::*;

   localparam int SHIFT_W = BUDGET_W + DIV_STEPS - 1;
   localparam int WW      = (COUNT_WIDTH + PCT_SCALE_W > SHIFT_W) ?
                            COUNT_WIDTH + PCT_SCALE_W : SHIFT_W;
   localparam int CNT_W   = $clog2(DIV_STEPS);

   logic [WW-1:0]        rem_ff, rem_in;
   logic [WW-1:0]        dvs_ff, dvs_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [WW-1:0]        scaled;
   logic                 ge;

   // Scale dividend by 100 with shifts: 64 + 32 + 4
   assign scaled = (WW'(dividend) << 6) + (WW'(dividend) << 5) + (WW'(dividend) << 2);
   assign ge     = (rem_ff >= dvs_ff);

   // One restoring step per cycle, divisor walks down from budget << 10
   always_comb begin
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      if (ctl.start) begin
         rem_in = scaled;
         dvs_in = WW'(divisor) << (DIV_STEPS - 1);
         quo_in = '0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_ff - dvs_ff : rem_ff;
         dvs_in = dvs_ff >> 1;
         quo_in = {quo_ff[DIV_STEPS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   // Step sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_STEPS - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // Top quotient bit set means 1024 or more: saturate
   assign sts.done = done_ff;
   assign sts.pct  = quo_ff[DIV_STEPS-1] ? PCT_MAX : quo_ff[PCT_W-1:0];

endmodule

// ----- rtl/core/data_quota_meter_core.sv -----
// Data quota meter: byte counters per session and per billing cycle with
// usage-percent alarms against a per-cycle budget.
// Request channel (req_*): tuser[0] selects record usage (0) or cycle reset
// (1), tuser[1] marks zero-rated traffic, tdata carries up and down bytes.
// Result channel (rsp_*): one item per request with percent, alert level,
// sticky aggressive flag and the five counters.
// Register channel (csr_*): always ready; write only while the block is idle.
// Flow: a usage item with a budget set passes through the add, divider load,
// 11 restoring steps of the percent divider (one quotient bit per cycle),
// result pick-up and output load; other items skip the divider. One item is
// in work at a time and req_tready is low from acceptance until the result
// is loaded, so a new item is taken only once the last one's result is loaded.
// The result sits in an output register; a stalled receiver holds it there,
// the next item may be accepted meanwhile and waits in its final state.
// Reset clears all counters, the percent and the aggressive flag, and loads
// register defaults: budget 0, warning 80, critical 95, auto-aggressive on,
// alerts off. No clearing pass is needed.
module data_quota_meter_core #(
   parameter int COUNT_WIDTH = 48
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: up_bytes[31:0], down_bytes[63:32]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dqm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: func[0], is_zero_rated[1]
   input  logic [dqm_pkg::REQ_USER_W-1:0]   req_tuser,
   // rsp_tdata: percent[9:0], alert_level[11:10], force_aggressive[12],
   // cycle_down_total[60:13], cycle_up_total[108:61], session_down_total[156:109],
   // session_up_total[204:157], zero_rated_total[252:205], zero fill[255:253]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dqm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dqm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dqm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import dqm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type              state_ff;

   // Configuration
   logic [BUDGET_W-1:0]    budget_ff;
   logic [PCT_W-1:0]       warn_ff;
   logic [PCT_W-1:0]       crit_ff;
   logic                   auto_agg_ff;
   logic                   alert_en_ff;

   // Latched request
   logic                   func_ff;
   logic                   zr_ff;
   logic [BYTES_W-1:0]     up_ff;
   logic [BYTES_W-1:0]     down_ff;

   // Metering state
   logic [COUNT_WIDTH-1:0] sess_up_ff, sess_down_ff, zr_sum_ff, cyc_up_ff, cyc_down_ff;
   logic [COUNT_WIDTH-1:0] sess_up_in, sess_down_in, zr_sum_in, cyc_up_in, cyc_down_in;
   logic [PCT_W-1:0]       pct_ff;
   logic                   agg_ff, agg_in;
   logic                   chk_ff;

   // Result register
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;

   logic [ALERT_W-1:0]     alert_in;
   logic                   rsp_free;
   logic                   req_fire;

   dqm_div_ctl_type        div_ctl;
   dqm_div_sts_type        div_sts;

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] acc,
                                                      input logic [BYTES_W-1:0] inc);
      logic [COUNT_WIDTH:0] sum;
      sum = {1'b0, acc} + (COUNT_WIDTH+1)'(inc);
      return sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign div_ctl.start = (state_ff == ST_LOAD);

   dqm_pct_div #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (cyc_down_ff),
      .divisor  (budget_ff),
      .sts      (div_sts)
   );

   // Saturating counter updates
   always_comb begin
      sess_up_in   = sat_add(sess_up_ff, up_ff);
      sess_down_in = sat_add(sess_down_ff, down_ff);
      zr_sum_in    = zr_ff ? sat_add(zr_sum_ff, down_ff) : zr_sum_ff;
      cyc_up_in    = zr_ff ? cyc_up_ff : sat_add(cyc_up_ff, up_ff);
      cyc_down_in  = zr_ff ? cyc_down_ff : sat_add(cyc_down_ff, down_ff);
   end

   // Threshold check, critical first
   always_comb begin
      alert_in = ALERT_NONE;
      if (chk_ff && alert_en_ff) begin
         priority if (pct_ff >= crit_ff) alert_in = ALERT_CRIT;
         else if (pct_ff >= warn_ff)     alert_in = ALERT_WARN;
      end
      agg_in = agg_ff || ((alert_in == ALERT_CRIT) && auto_agg_ff);
   end

   // Register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff   <= '0;
         warn_ff     <= PCT_W'(80);
         crit_ff     <= PCT_W'(95);
         auto_agg_ff <= 1'b1;
         alert_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BUDGET:   budget_ff   <= csr_data[BUDGET_W-1:0];
            REG_WARN:     warn_ff     <= csr_data[PCT_W-1:0];
            REG_CRIT:     crit_ff     <= csr_data[PCT_W-1:0];
            REG_AUTO_AGG: auto_agg_ff <= csr_data[0];
            REG_ALERT_EN: alert_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Capture the request item
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff <= req_tuser[0];
         zr_ff   <= req_tuser[1];
         up_ff   <= req_tdata[BYTES_W-1:0];
         down_ff <= req_tdata[REQ_DATA_W-1:BYTES_W];
      end
   end

   // Sequencer, metering state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sess_up_ff   <= '0;
         sess_down_ff <= '0;
         zr_sum_ff    <= '0;
         cyc_up_ff    <= '0;
         cyc_down_ff  <= '0;
         pct_ff       <= '0;
         agg_ff       <= 1'b0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the taken result unless a new one loads in this cycle
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               chk_ff <= 1'b0;
               if (func_ff == FUNC_RESET) begin
                  cyc_up_ff   <= '0;
                  cyc_down_ff <= '0;
                  pct_ff      <= '0;
                  state_ff    <= ST_DONE;
               end else begin
                  sess_up_ff   <= sess_up_in;
                  sess_down_ff <= sess_down_in;
                  zr_sum_ff    <= zr_sum_in;
                  cyc_up_ff    <= cyc_up_in;
                  cyc_down_ff  <= cyc_down_in;
                  state_ff     <= (budget_ff != '0) ? ST_LOAD : ST_DONE;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_sts.done) begin
                  pct_ff   <= div_sts.pct;
                  chk_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  agg_ff       <= agg_in;
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {3'b000,
                                   OUT_CNT_W'(zr_sum_ff),
                                   OUT_CNT_W'(sess_up_ff),
                                   OUT_CNT_W'(sess_down_ff),
                                   OUT_CNT_W'(cyc_up_ff),
                                   OUT_CNT_W'(cyc_down_ff),
                                   agg_in, alert_in, pct_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/core/dqm_checker.sv -----
module dqm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [dqm_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import dqm_pkg::*;

   // One item in work: no new item in the cycle after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while previous one still in work");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // Alert level is one of the three defined codes
   a_alert_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:10] == ALERT_NONE) || (rsp_tdata[11:10] == ALERT_WARN) ||
                     (rsp_tdata[11:10] == ALERT_CRIT))
      else $error("undefined alert level");

   // The aggressive flag never clears between results
   a_agg_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |=> !rsp_tvalid || rsp_tdata[12])
      else $error("aggressive flag cleared");

endmodule

bind data_quota_meter_core dqm_checker u_dqm_checker (.*);
